[hdl/dsc_pkg.sv]
package dsc_pkg;

	localparam int unsigned ALPHABET_SIZE = 34;
	localparam int unsigned SHIFT_RESET   = 6;
	localparam int unsigned QUEUE_DEPTH   = 2;
	localparam int unsigned QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned SYM_W         = 6;
	localparam int unsigned LETTER_W      = 5;
	localparam int unsigned BYTE_W        = 8;

	typedef logic [SYM_W-1:0]    sym_t;
	typedef logic [LETTER_W-1:0] letter_t;

	// One queue entry: the symbols caused by one input, before the shift
	typedef struct packed {
		logic two;
		sym_t sym0;
		sym_t sym1;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} queue_wr_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} queue_rd_t;

	function automatic sym_t single_sym(input letter_t l);
		sym_t s;
		case (l)
			5'd0:    s = 6'd0;
			5'd1:    s = 6'd1;
			5'd2:    s = 6'd2;
			5'd3:    s = 6'd4;
			5'd4:    s = 6'd5;
			5'd5:    s = 6'd8;
			5'd6:    s = 6'd9;
			5'd7:    s = 6'd10;
			5'd8:    s = 6'd11;
			5'd9:    s = 6'd12;
			5'd10:   s = 6'd13;
			5'd11:   s = 6'd15;
			5'd12:   s = 6'd16;
			5'd13:   s = 6'd17;
			5'd14:   s = 6'd19;
			5'd15:   s = 6'd21;
			5'd16:   s = 6'd22;
			5'd17:   s = 6'd23;
			5'd18:   s = 6'd24;
			5'd19:   s = 6'd26;
			5'd20:   s = 6'd28;
			5'd21:   s = 6'd29;
			5'd22:   s = 6'd30;
			5'd23:   s = 6'd31;
			5'd24:   s = 6'd32;
			5'd25:   s = 6'd33;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

	// Letters that may open a digraph: a c e k n o s t
	function automatic logic starts_pair(input letter_t l);
		logic r;
		case (l)
			5'd0, 5'd2, 5'd4, 5'd10, 5'd13, 5'd14, 5'd18, 5'd19: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic letter_t pair_second(input letter_t l);
		letter_t r;
		case (l)
			5'd0:    r = 5'd4;   // ae
			5'd2:    r = 5'd7;   // ch
			5'd4:    r = 5'd14;  // eo
			5'd10:   r = 5'd7;   // kh
			5'd13:   r = 5'd6;   // ng
			5'd14:   r = 5'd14;  // oo
			5'd18:   r = 5'd7;   // sh
			5'd19:   r = 5'd7;   // th
			default: r = 5'd31;
		endcase
		return r;
	endfunction

	function automatic sym_t pair_sym(input letter_t l);
		sym_t s;
		case (l)
			5'd0:    s = 6'd6;
			5'd2:    s = 6'd3;
			5'd4:    s = 6'd7;
			5'd10:   s = 6'd14;
			5'd13:   s = 6'd18;
			5'd14:   s = 6'd20;
			5'd18:   s = 6'd25;
			5'd19:   s = 6'd27;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

endpackage

[hdl/dsc_if.sv]
interface dsc_char_if import dsc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] char_byte;
	logic              line_end;

	modport source(output valid, output char_byte, output line_end, input ready);
	modport sink(input valid, input char_byte, input line_end, output ready);
endinterface

interface dsc_glyph_if import dsc_pkg::*; ();
	logic valid;
	logic ready;
	sym_t glyph;
	logic last_of_run;

	modport source(output valid, output glyph, output last_of_run, input ready);
	modport sink(input valid, input glyph, input last_of_run, output ready);
endinterface

[hdl/dsc_front.sv]
module dsc_front import dsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dsc_char_if.sink   char_in,
	input  logic       queue_full,
	output queue_wr_t  queue_wr
);

	letter_t held_letter_q;
	logic    held_valid_q;

	logic    accept;
	logic    is_letter;
	letter_t letter;
	letter_t held_nxt;
	logic    held_valid_nxt;
	logic    consumed;
	logic [1:0] cnt;
	sym_t    sym0;
	sym_t    sym1;

	assign char_in.ready = !queue_full;
	assign accept = char_in.valid && char_in.ready;

	// 'A'..'Z' and 'a'..'z' both carry 1..26 in the low five bits
	assign is_letter = (char_in.char_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]});
	assign letter = char_in.char_byte[LETTER_W-1:0] - 5'd1;

	always_comb begin
		held_nxt = held_letter_q;
		held_valid_nxt = held_valid_q;
		consumed = 1'b0;
		cnt = 2'd0;
		sym0 = '0;
		sym1 = '0;
		if (is_letter) begin
			if (held_valid_q) begin
				if (starts_pair(held_letter_q) && pair_second(held_letter_q) == letter) begin
					sym0 = pair_sym(held_letter_q);
					consumed = 1'b1;
				end else begin
					sym0 = single_sym(held_letter_q);
				end
				cnt = 2'd1;
				held_valid_nxt = 1'b0;
			end
			if (!consumed) begin
				if (starts_pair(letter)) begin
					held_nxt = letter;
					held_valid_nxt = 1'b1;
				end else begin
					if (cnt == 2'd0) begin
						sym0 = single_sym(letter);
					end else begin
						sym1 = single_sym(letter);
					end
					cnt = cnt + 2'd1;
				end
			end
		end else if (held_valid_q) begin
			sym0 = single_sym(held_letter_q);
			cnt = 2'd1;
			held_valid_nxt = 1'b0;
		end
		// line end flushes whatever is still held
		if (char_in.line_end && held_valid_nxt) begin
			if (cnt == 2'd0) begin
				sym0 = single_sym(held_nxt);
			end else begin
				sym1 = single_sym(held_nxt);
			end
			cnt = cnt + 2'd1;
			held_valid_nxt = 1'b0;
		end
	end

	always_comb begin
		queue_wr.valid = accept && (cnt != 2'd0);
		queue_wr.entry.two = (cnt == 2'd2);
		queue_wr.entry.sym0 = sym0;
		queue_wr.entry.sym1 = sym1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_letter_q <= '0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			held_letter_q <= held_nxt;
			held_valid_q <= held_valid_nxt;
		end
	end

endmodule

[hdl/dsc_queue.sv]
module dsc_queue import dsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  queue_wr_t queue_wr,
	output logic      full,
	output queue_rd_t queue_rd,
	input  logic      pop
);

	entry_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign do_push = queue_wr.valid && !full;
	assign do_pop = pop && (count_q != '0);

	always_comb begin
		queue_rd.valid = (count_q != '0);
		queue_rd.entry = mem_q[rd_ptr_q];
	end

	function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
		return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= queue_wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/dsc_back.sv]
module dsc_back import dsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  sym_t       cfg_data,
	input  queue_rd_t  queue_rd,
	output logic       pop,
	dsc_glyph_if.source glyph_out
);

	sym_t       shift_q;
	sym_t       shift_mod;
	logic       second_q;
	logic       out_valid_q;
	sym_t       glyph_q;
	logic       last_q;
	logic       load;
	logic       take;
	sym_t       sym;
	logic       last;
	logic [SYM_W:0] sum;
	sym_t       glyph_nxt;

	// register may hold up to 63: fold once, then one more fold after the add
	assign shift_mod = (shift_q >= SYM_W'(ALPHABET_SIZE)) ?
		shift_q - SYM_W'(ALPHABET_SIZE) : shift_q;

	assign load = !out_valid_q || glyph_out.ready;
	assign take = load && queue_rd.valid;
	assign sym = second_q ? queue_rd.entry.sym1 : queue_rd.entry.sym0;
	assign last = second_q || !queue_rd.entry.two;
	assign pop = take && last;

	always_comb begin
		sum = {1'b0, sym} + {1'b0, shift_mod};
		if (sum >= (SYM_W+1)'(ALPHABET_SIZE)) begin
			glyph_nxt = SYM_W'(sum - (SYM_W+1)'(ALPHABET_SIZE));
		end else begin
			glyph_nxt = sum[SYM_W-1:0];
		end
	end

	assign glyph_out.valid = out_valid_q;
	assign glyph_out.glyph = glyph_q;
	assign glyph_out.last_of_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SYM_W'(SHIFT_RESET);
		end else if (cfg_we) begin
			shift_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= queue_rd.valid;
			if (take) begin
				second_q <= !last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			glyph_q <= glyph_nxt;
			last_q <= last;
		end
	end

endmodule

[hdl/digraph_shift_cipher_encoder_top.sv]
// Path: each result is registered in the queue and then in the output
//   register; a digraph start letter waits for the next byte or the line end.
// Throughput: one input byte per cycle while the queue is not full;
//   a byte's two results take turns at the output, absorbed by a 2-entry queue.
// Reset (arst_n low, asynchronous): nothing held, queue and output empty,
//   shift_amount back to 6.
module digraph_shift_cipher_encoder_top import dsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  sym_t        cfg_data,
	dsc_char_if.sink    char_in,
	dsc_glyph_if.source glyph_out
);

	queue_wr_t queue_wr;
	queue_rd_t queue_rd;
	logic      queue_full;
	logic      pop;

	dsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.queue_full (queue_full),
		.queue_wr   (queue_wr)
	);

	dsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.queue_wr (queue_wr),
		.full     (queue_full),
		.queue_rd (queue_rd),
		.pop      (pop)
	);

	dsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.queue_rd  (queue_rd),
		.pop       (pop),
		.glyph_out (glyph_out)
	);

endmodule

[hdl/dsc_checker.sv]
module dsc_checker import dsc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input sym_t glyph,
	input logic last_of_run
);

	a_glyph_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> glyph < SYM_W'(ALPHABET_SIZE))
		else $error("glyph out of alphabet");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(glyph) && $stable(last_of_run))
		else $error("stalled output transaction changed");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

	// input backpressure only arises behind a pending output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind digraph_shift_cipher_encoder_top dsc_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (char_in.ready),
	.out_valid   (glyph_out.valid),
	.out_ready   (glyph_out.ready),
	.glyph       (glyph_out.glyph),
	.last_of_run (glyph_out.last_of_run)
);
